// ===== src/lrdt_pkg.sv =====
`timescale 1ns / 1ps
// Package for light_reading_to_decimal_text: constants, shared types and the
// exponent/mantissa scaling function. No dependencies.
package lrdt_pkg;

    localparam int RAW_W        = 16;
    localparam int VALUE_W      = 16;
    localparam int CHAR_W       = 8;
    localparam int DIGIT_W      = 4;
    localparam int MAX_DIGITS   = 5;
    localparam int NUM_W        = 3;
    localparam int POS_W        = 4;
    localparam int PAD_COUNT    = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = 1;
    localparam int QUEUE_CNT_W  = 2;

    localparam logic [11:0] MANT_MASK = 12'hFFF;
    localparam logic [3:0]  EXP_MASK  = 4'hF;
    localparam logic [3:0]  EXP_UNITY = 4'd6;
    localparam logic [3:0]  EXP_LEFT_MAX = 4'd11;

    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONVERT,
        F_HANDOFF
    } lrdt_front_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0]                   value;
        logic [MAX_DIGITS-1:0][DIGIT_W-1:0]   digits;   // [0] is most significant
        logic [NUM_W-1:0]                     num;
    } lrdt_entry_t;

    typedef struct packed {
        logic        valid;
        lrdt_entry_t entry;
    } lrdt_push_t;

    typedef struct packed {
        logic        valid;
        lrdt_entry_t entry;
    } lrdt_head_t;

    function automatic logic [VALUE_W-1:0] lrdt_scale(input logic [RAW_W-1:0] raw);
        logic [3:0]         e;
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] r;
        e = raw[15:12] & EXP_MASK;
        m = {4'd0, raw[11:0] & MANT_MASK};
        if (e < EXP_UNITY)
            r = m >> (EXP_UNITY - e);
        else if (e > EXP_UNITY && e <= EXP_LEFT_MAX)
            r = m << (e - EXP_UNITY);
        else
            r = m;
        return r;
    endfunction

endpackage

// ===== src/lrdt_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: valid/ready with the raw sensor word.
// Depends on lrdt_pkg.
interface lrdt_in_if;
    logic                          valid;
    logic                          ready;
    logic [lrdt_pkg::RAW_W-1:0]    raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface

// ===== src/lrdt_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: valid/ready with one text character per transfer.
// Depends on lrdt_pkg.
interface lrdt_out_if;
    logic                          valid;
    logic                          ready;
    logic [lrdt_pkg::CHAR_W-1:0]   text_char;
    logic                          last_char;
    logic [lrdt_pkg::VALUE_W-1:0]  lux_value;

    modport source (output valid, output text_char, output last_char, output lux_value,
                    input ready);
    modport sink   (input valid, input text_char, input last_char, input lux_value,
                    output ready);
endinterface

// ===== src/lrdt_front.sv =====
`timescale 1ns / 1ps
// Front end: takes a reading, scales it and splits it into decimal digits,
// one digit per cycle. Depends on lrdt_pkg and lrdt_in_if.
module lrdt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    lrdt_in_if.sink              reading,
    output lrdt_pkg::lrdt_push_t push,
    input  logic                 full
);
    import lrdt_pkg::*;

    lrdt_front_state_t                  state_reg, state_next;
    logic [VALUE_W-1:0]                 value_reg, value_next;
    logic [VALUE_W-1:0]                 work_reg, work_next;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_reg, digits_next;
    logic [NUM_W-1:0]                   num_reg, num_next;

    logic [32:0]        prod;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] rem;

    // divide by ten through reciprocal multiply
    assign prod = {16'd0, work_reg} * {16'd0, DIV10_MUL};
    assign quot = {3'd0, prod[DIV10_SHIFT+12:DIV10_SHIFT]};
    assign rem  = work_reg - ((quot << 3) + (quot << 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        work_reg   <= work_next;
        digits_reg <= digits_next;
        num_reg    <= num_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        value_next    = value_reg;
        work_next     = work_reg;
        digits_next   = digits_reg;
        num_next      = num_reg;
        reading.ready = 1'b0;
        push.valid    = 1'b0;
        push.entry.value  = value_reg;
        push.entry.digits = digits_reg;
        push.entry.num    = num_reg;
        case (state_reg)
            F_IDLE:
            begin
                reading.ready = 1'b1;
                if (reading.valid)
                begin
                    value_next = lrdt_scale(reading.raw_word);
                    work_next  = value_next;
                    num_next   = '0;
                    state_next = F_CONVERT;
                end
            end
            F_CONVERT:
            begin
                digits_next[0] = rem[DIGIT_W-1:0];
                for (int i = 1; i < MAX_DIGITS; i++)
                begin
                    digits_next[i] = digits_reg[i-1];
                end
                work_next = quot;
                num_next  = num_reg + NUM_W'(1);
                if (quot == '0 || num_reg == NUM_W'(MAX_DIGITS - 1))
                begin
                    state_next = F_HANDOFF;
                end
            end
            F_HANDOFF:
            begin
                push.valid = !full;
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lrdt_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of converted readings between front and back end.
// Depends on lrdt_pkg.
module lrdt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrdt_pkg::lrdt_push_t push,
    output logic                 full,
    output lrdt_pkg::lrdt_head_t head,
    input  logic                 pop
);
    import lrdt_pkg::*;

    lrdt_entry_t            slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== src/lrdt_back.sv =====
`timescale 1ns / 1ps
// Back end: emits the digits of one queued reading, then the space padding,
// one character per transfer. Depends on lrdt_pkg and lrdt_out_if.
module lrdt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrdt_pkg::lrdt_head_t head,
    output logic                 pop,
    lrdt_out_if.source           text
);
    import lrdt_pkg::*;

    logic                busy_reg, busy_next;
    lrdt_entry_t         ent_reg, ent_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                valid_reg, valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic [VALUE_W-1:0]  lux_reg, lux_next;

    logic [POS_W-1:0]    end_pos;
    logic                slot_free;

    assign end_pos   = POS_W'(ent_reg.num) + POS_W'(PAD_COUNT - 1);
    assign slot_free = !valid_reg || text.ready;
    assign pop       = head.valid && !busy_reg;

    assign text.valid     = valid_reg;
    assign text.text_char = char_reg;
    assign text.last_char = last_reg;
    assign text.lux_value = lux_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        ent_next   = ent_reg;
        pos_next   = pos_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        lux_next   = lux_reg;
        if (valid_reg && text.ready)
        begin
            valid_next = 1'b0;
        end
        if (!busy_reg)
        begin
            if (head.valid)
            begin
                busy_next = 1'b1;
                ent_next  = head.entry;
                pos_next  = '0;
            end
        end
        else if (slot_free)
        begin
            valid_next = 1'b1;
            lux_next   = ent_reg.value;
            last_next  = pos_reg == end_pos;
            if (pos_reg < POS_W'(ent_reg.num))
                char_next = CHAR_ZERO + CHAR_W'(ent_reg.digits[pos_reg[NUM_W-1:0]]);
            else
                char_next = CHAR_SPACE;
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == end_pos)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
        lux_reg  <= lux_next;
    end

endmodule

// ===== src/light_reading_to_decimal_text.sv =====
`timescale 1ns / 1ps
// Light reading to decimal text. After the input transfer, the front divider produces the
// decimal digits, then hands off to the queue; the back end pops the queue head and
// emits characters through the output register. Throughput: one character per cycle
// while the output is ready, apart from loading each queue head; a reading is emitted
// as 5 to 9 characters, with conversion of the next reading overlapped through a
// two-entry queue. Reset clears all control state.
module light_reading_to_decimal_text (
    input  logic        clk,
    input  logic        rst_n,
    lrdt_in_if.sink     reading,
    lrdt_out_if.source  text
);
    import lrdt_pkg::*;

    lrdt_push_t push;
    lrdt_head_t head;
    logic       full;
    logic       pop;

    lrdt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .reading (reading),
        .push    (push),
        .full    (full)
    );

    lrdt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    lrdt_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .text  (text)
    );

endmodule
